>>> rtl/core/srr_pkg.sv
// shared constants and controller/datapath types for the selective repeat receiver
`timescale 1ns / 1ps

package srr_pkg;

   // packet geometry
   localparam int PAYLOAD_BYTES = 20;
   localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;
   localparam int LOW_W         = 64;
   localparam int MID_W         = 64;
   localparam int HIGH_W        = 32;
   localparam int WORD_W        = 32;

   // checksum is accumulated one 32-bit group of four bytes per cycle
   localparam int BYTES_PER_GROUP = 4;
   localparam int GROUPS          = PAYLOAD_BYTES / BYTES_PER_GROUP;
   localparam int GROUP_W         = 3;

   // ack packet fields
   localparam int ACK_NUM_W   = 4;
   localparam int ACK_CHECK_W = 10;
   localparam int ZERO_CHAR   = 48;
   localparam logic [ACK_CHECK_W-1:0] ACK_BASE = ACK_CHECK_W'(PAYLOAD_BYTES * ZERO_CHAR);

   // result kinds
   localparam logic KIND_DELIVER = 1'b0;
   localparam logic KIND_ACK     = 1'b1;

   // commands from the controller
   typedef struct packed {
      logic               load;      // capture an input beat, start the sum
      logic               add_group; // add one byte group to the sum
      logic [GROUP_W-1:0] group;     // which byte group
      logic               check;     // checksum and window test, store
      logic               take;      // read head slot, clear it, advance
      logic               load_dlv;  // put the read payload in the output register
      logic               load_ack;  // put the ack in the output register
   } srr_cmd_type;

   // status back to the controller
   typedef struct packed {
      logic accepted;  // current packet intact and inside the window
      logic head_full; // slot of the next in-order number holds a payload
      logic out_free;  // output register can take a beat this cycle
   } srr_status_type;

endpackage

>>> rtl/core/srr_if.sv
// valid/ready channel interfaces for packet input and result output
`timescale 1ns / 1ps

interface srr_req_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  seq_number;
   logic signed [31:0]  ack_field;
   logic signed [31:0]  check_value;
   logic [63:0]         payload_low;
   logic [63:0]         payload_mid;
   logic [31:0]         payload_high;

   modport source (output valid, seq_number, ack_field, check_value,
                   payload_low, payload_mid, payload_high, input ready);
   modport sink   (input valid, seq_number, ack_field, check_value,
                   payload_low, payload_mid, payload_high, output ready);
endinterface

interface srr_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [63:0] out_payload_low;
   logic [63:0] out_payload_mid;
   logic [31:0] out_payload_high;
   logic        ack_bit;
   logic [3:0]  ack_number;
   logic [9:0]  ack_check;
   logic        last_result;

   modport source (output valid, result_kind, out_payload_low, out_payload_mid,
                   out_payload_high, ack_bit, ack_number, ack_check, last_result,
                   input ready);
   modport sink   (input valid, result_kind, out_payload_low, out_payload_mid,
                   out_payload_high, ack_bit, ack_number, ack_check, last_result,
                   output ready);
endinterface

>>> rtl/core/srr_ctrl.sv
// sequencing state machine: checksum groups, check, delivery loop, ack
`timescale 1ns / 1ps

module srr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  srr_pkg::srr_status_type status,
   output srr_pkg::srr_cmd_type    cmd
);
   import srr_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SUM   = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_DELIV = 3'd4;
   localparam logic [2:0] ST_ACK   = 3'd5;

   localparam logic [GROUP_W-1:0] LAST_GROUP = GROUP_W'(GROUPS - 1);

   logic [2:0]         state_ff, state_in;
   logic [GROUP_W-1:0] group_ff, group_in;

   // no input beat is taken while reset is held
   assign req_ready = (state_ff == ST_IDLE) && !reset;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      group_in      = group_ff;
      cmd           = '0;
      cmd.group     = group_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               group_in = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.add_group = 1'b1;
            group_in      = group_ff + 1'b1;
            if (group_ff == LAST_GROUP) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.accepted && status.head_full) begin
               cmd.take = 1'b1;
               state_in = ST_DELIV;
            end else begin
               state_in = ST_ACK;
            end
         end
         ST_DELIV: begin
            if (status.out_free) begin
               cmd.load_dlv = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_ACK: begin
            if (status.out_free) begin
               cmd.load_ack = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         group_ff <= '0;
      end else begin
         state_ff <= state_in;
         group_ff <= group_in;
      end
   end

endmodule

>>> rtl/core/srr_datapath.sv
// checksum accumulator, window test, slot store and output register
`timescale 1ns / 1ps

module srr_datapath #(
   parameter int WINDOW    = 8,
   parameter int SEQ_SPACE = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  srr_pkg::srr_cmd_type    cmd,
   output srr_pkg::srr_status_type status,
   input  logic signed [31:0]      seq_number,
   input  logic signed [31:0]      ack_field,
   input  logic signed [31:0]      check_value,
   input  logic [63:0]             payload_low,
   input  logic [63:0]             payload_mid,
   input  logic [31:0]             payload_high,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    result_kind,
   output logic [63:0]             out_payload_low,
   output logic [63:0]             out_payload_mid,
   output logic [31:0]             out_payload_high,
   output logic                    ack_bit,
   output logic [3:0]              ack_number,
   output logic [9:0]              ack_check,
   output logic                    last_result
);
   import srr_pkg::*;

   localparam int SEQ_W  = $clog2(SEQ_SPACE);
   localparam int SLOT_W = $clog2(WINDOW);
   localparam int TBL_N  = 2 ** SEQ_W;

   typedef logic [SLOT_W-1:0] slot_tbl_type [TBL_N];

   // slot of each sequence number, built by counting around the window
   function automatic slot_tbl_type build_slot_tbl();
      slot_tbl_type tbl;
      int           c;
      c = 0;
      for (int i = 0; i < TBL_N; i++) begin
         tbl[i] = SLOT_W'(c);
         c = (c == WINDOW - 1) ? 0 : c + 1;
      end
      return tbl;
   endfunction

   localparam slot_tbl_type SLOT_OF = build_slot_tbl();

   localparam logic [SEQ_W-1:0] SEQ_TOP = SEQ_W'(SEQ_SPACE - 1);

   // captured packet
   logic [WORD_W-1:0]    sum_ff, sum_in;
   logic [WORD_W-1:0]    seq_ff;
   logic [WORD_W-1:0]    chk_ff;
   logic [PAYLOAD_W-1:0] payload_ff;

   // receiver state
   logic [SEQ_W-1:0]     exp_ff, exp_in;
   logic                 toggle_ff;
   logic                 accepted_ff;
   logic [WINDOW-1:0]    slot_full_ff;

   // slot store with registered read
   logic [PAYLOAD_W-1:0] slot_mem [WINDOW];
   logic [PAYLOAD_W-1:0] rd_ff;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 kind_ff;
   logic [PAYLOAD_W-1:0] out_pay_ff;
   logic                 bit_ff;
   logic [ACK_NUM_W-1:0] num_ff;
   logic [ACK_CHECK_W-1:0] check_ff;
   logic                 last_ff;

   // window test signals
   logic [SEQ_W-1:0]     seq_lo;
   logic [SEQ_W:0]       diff;
   logic [SEQ_W:0]       offset;
   logic                 in_space;
   logic                 pass;
   logic [SLOT_W-1:0]    seq_slot;
   logic [SLOT_W-1:0]    head_slot;

   // byte group adder
   logic [WORD_W-1:0]    group_word;
   logic [WORD_W-1:0]    group_sum;

   // ack fields
   logic [SEQ_W-1:0]     prev_exp;
   logic [WORD_W-1:0]    ack_wide;
   logic [ACK_NUM_W-1:0] ack_num;
   logic [ACK_CHECK_W-1:0] ack_chk;

   // four signed bytes of the selected group
   always_comb begin
      group_word = payload_ff[{cmd.group, 5'd0} +: WORD_W];
      group_sum  = sum_ff;
      for (int b = 0; b < BYTES_PER_GROUP; b++) begin
         group_sum = group_sum + {{24{group_word[8*b+7]}}, group_word[8*b +: 8]};
      end
   end

   always_comb begin
      if (cmd.load) begin
         sum_in = WORD_W'(seq_number) + WORD_W'(ack_field);
      end else if (cmd.add_group) begin
         sum_in = group_sum;
      end else begin
         sum_in = sum_ff;
      end
   end

   // window test on the captured number
   assign seq_lo    = seq_ff[SEQ_W-1:0];
   assign in_space  = !seq_ff[WORD_W-1] && (seq_ff < WORD_W'(SEQ_SPACE));
   assign diff      = {1'b0, seq_lo} - {1'b0, exp_ff};
   assign offset    = diff[SEQ_W] ? diff + (SEQ_W+1)'(SEQ_SPACE) : diff;
   assign pass      = (sum_ff == chk_ff) && in_space
                      && (offset < (SEQ_W+1)'(WINDOW));
   assign seq_slot  = SLOT_OF[seq_lo];
   assign head_slot = SLOT_OF[exp_ff];

   // next in-order number after a delivery
   assign exp_in = (exp_ff == SEQ_TOP) ? '0 : exp_ff + 1'b1;

   // ack number and checksum
   assign prev_exp = (exp_ff == '0) ? SEQ_TOP : exp_ff - 1'b1;
   assign ack_wide = accepted_ff ? seq_ff : WORD_W'(prev_exp);
   assign ack_num  = ack_wide[ACK_NUM_W-1:0];
   assign ack_chk  = ACK_BASE + ACK_CHECK_W'(toggle_ff) + ACK_CHECK_W'(ack_num);

   assign status.accepted  = accepted_ff;
   assign status.head_full = slot_full_ff[head_slot];
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // packet capture and checksum
   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (cmd.load) begin
         seq_ff     <= WORD_W'(seq_number);
         chk_ff     <= WORD_W'(check_value);
         payload_ff <= {payload_high, payload_mid, payload_low};
      end
   end

   // receiver control state
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff       <= '0;
         toggle_ff    <= 1'b1;
         accepted_ff  <= 1'b0;
         slot_full_ff <= '0;
      end else begin
         if (cmd.check) begin
            accepted_ff <= pass;
            if (pass) begin
               slot_full_ff[seq_slot] <= 1'b1;
            end
         end
         if (cmd.take) begin
            slot_full_ff[head_slot] <= 1'b0;
            exp_ff                  <= exp_in;
         end
         if (cmd.load_ack) begin
            toggle_ff <= !toggle_ff;
         end
      end
   end

   // slot store, a full slot is never overwritten
   always_ff @(posedge clock) begin
      if (cmd.check && pass && !slot_full_ff[seq_slot]) begin
         slot_mem[seq_slot] <= payload_ff;
      end
      if (cmd.take) begin
         rd_ff <= slot_mem[head_slot];
      end
   end

   // output register valid
   always_comb begin
      if (cmd.load_dlv || cmd.load_ack) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (cmd.load_dlv) begin
         kind_ff    <= KIND_DELIVER;
         out_pay_ff <= rd_ff;
         bit_ff     <= 1'b0;
         num_ff     <= '0;
         check_ff   <= '0;
         last_ff    <= 1'b0;
      end else if (cmd.load_ack) begin
         kind_ff    <= KIND_ACK;
         out_pay_ff <= '0;
         bit_ff     <= toggle_ff;
         num_ff     <= ack_num;
         check_ff   <= ack_chk;
         last_ff    <= 1'b1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign result_kind      = kind_ff;
   assign out_payload_low  = out_pay_ff[LOW_W-1:0];
   assign out_payload_mid  = out_pay_ff[LOW_W+MID_W-1:LOW_W];
   assign out_payload_high = out_pay_ff[PAYLOAD_W-1:LOW_W+MID_W];
   assign ack_bit          = bit_ff;
   assign ack_number       = num_ff;
   assign ack_check        = check_ff;
   assign last_result      = last_ff;

   // a delivery only drains a stored slot of an accepted packet
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> (accepted_ff && slot_full_ff[head_slot]))
      else $error("delivery from an empty slot or a rejected packet");

   // a taken slot is empty on the next cycle
   a_take_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> !slot_full_ff[$past(head_slot)])
      else $error("slot still marked full after delivery");

   // the output register is only loaded when it can take a beat
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_dlv || cmd.load_ack) |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten while a beat waits");

   // delivery and ack never load together
   a_one_load: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_dlv && cmd.load_ack))
      else $error("delivery and ack loaded in the same cycle");

endmodule

>>> rtl/core/selective_repeat_receiver.sv
// selective repeat arq receiver top level: controller plus datapath
//
//   channel   dir   modport          beat
//   req_chan  in    srr_req_if.sink  one data packet: seq, ack field, checksum, 20 bytes
//   rsp_chan  out   srr_rsp_if.source  one delivered payload or the closing ack
//
// a packet goes from its input beat to the check through capture with seq plus ack,
// the checksum adder over five groups of four bytes each, then window test and store.
// each in-order delivery then runs through slot store read and output load, and the ack
// through final head slot test and output load, before the next input ready.
// a stalled output holds the result in the output register and the sequencer waits there;
// a new input beat is taken as soon as the ack is loaded, while that ack still waits.
// reset is synchronous: expected number zero, ack bit one, every slot marked empty,
// input ready low while reset is held.
`timescale 1ns / 1ps

module selective_repeat_receiver #(
   parameter int WINDOW    = 8,
   parameter int SEQ_SPACE = 16
) (
   input  logic     clock,
   input  logic     reset,
   srr_req_if.sink  req_chan,
   srr_rsp_if.source rsp_chan
);
   import srr_pkg::*;

   srr_cmd_type    cmd;
   srr_status_type status;
   logic           ctrl_ready;

   assign req_chan.ready = ctrl_ready;

   // sequencer
   srr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ctrl_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath and output register
   srr_datapath #(
      .WINDOW    (WINDOW),
      .SEQ_SPACE (SEQ_SPACE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .seq_number       (req_chan.seq_number),
      .ack_field        (req_chan.ack_field),
      .check_value      (req_chan.check_value),
      .payload_low      (req_chan.payload_low),
      .payload_mid      (req_chan.payload_mid),
      .payload_high     (req_chan.payload_high),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .result_kind      (rsp_chan.result_kind),
      .out_payload_low  (rsp_chan.out_payload_low),
      .out_payload_mid  (rsp_chan.out_payload_mid),
      .out_payload_high (rsp_chan.out_payload_high),
      .ack_bit          (rsp_chan.ack_bit),
      .ack_number       (rsp_chan.ack_number),
      .ack_check        (rsp_chan.ack_check),
      .last_result      (rsp_chan.last_result)
   );

endmodule
